// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the nearest neighbor unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// implication checked on every rising clock edge outside reset
`define MNN_ASSERT(lbl, ck, rstn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);
// invariant that holds on every rising clock edge outside reset
`define MNN_ASSERT_ALWAYS(lbl, ck, rstn, expr, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (expr)) else $error(msg);
`else
`define MNN_ASSERT(lbl, ck, rstn, prop, msg)
`define MNN_ASSERT_ALWAYS(lbl, ck, rstn, expr, msg)
`endif
`endif

// ===== hw/rtl/mnn_pkg.sv =====
// shared constants for the manhattan nearest neighbor unit
package mnn_pkg;
  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 24;
  localparam int IDX_BITS   = $clog2(MAX_POINTS);
  localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
  localparam int DIST_BITS  = COORD_BITS + 1;
  localparam int PT_BITS    = 2 * COORD_BITS;
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;
endpackage

// ===== hw/rtl/mnn_ram.sv =====
// generic single write port ram with registered read
module mnn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/manhattan_nearest_neighbor_distances_unit.sv =====
// manhattan nearest neighbor unit: point store and per query distance scan
//
//  channel | signals                                   | moves
//  in      | in_valid in_ready in_mode in_x/y_coord idx | one load or query word
//  out     | out_valid out_ready distance alone bad     | one result word per query
//
// a query on a valid index with two or more points goes through the latch, scan and
// done states; the scan reads every loaded point from the point ram, one entry per cycle,
// and done waits for a free result register. bad index and lone point queries answer the next cycle.
// reset clears the point count, the state and the result valid flag; ram contents stay.
// a query waits while a result is still pending; loads go in regardless.
// no input word is taken while a scan runs
`include "assert_macros.svh"
module manhattan_nearest_neighbor_distances_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_mode,
  input  logic signed [mnn_pkg::COORD_BITS-1:0]  in_x_coord,
  input  logic signed [mnn_pkg::COORD_BITS-1:0]  in_y_coord,
  input  logic [mnn_pkg::IDX_BITS-1:0]           in_point_index,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [mnn_pkg::DIST_BITS-1:0]          out_distance,
  output logic                                   out_alone,
  output logic                                   out_bad_index
);
  typedef enum logic [1:0] {ST_IDLE, ST_LATCH, ST_SCAN, ST_DONE} state_t;

  state_t                              state_r;
  logic [mnn_pkg::CNT_BITS-1:0]        cnt_r;
  logic [mnn_pkg::IDX_BITS-1:0]        qidx_r;
  logic [mnn_pkg::IDX_BITS-1:0]        j_r;
  logic signed [mnn_pkg::COORD_BITS-1:0] px_r, py_r;
  logic [mnn_pkg::DIST_BITS-1:0]       best_r, best_nxt;
  logic                                out_valid_r, out_alone_r, out_bad_r;
  logic [mnn_pkg::DIST_BITS-1:0]       out_dist_r;

  logic                                out_free, acc, ram_we, last, out_load;
  logic [mnn_pkg::IDX_BITS-1:0]        raddr;
  logic [mnn_pkg::PT_BITS-1:0]         rdata;
  logic signed [mnn_pkg::COORD_BITS-1:0] rx, ry;
  logic signed [mnn_pkg::DIST_BITS-1:0]  dx, dy;
  logic [mnn_pkg::DIST_BITS-1:0]       ax, ay, pt_dist;

  // handshake
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && ((in_mode == mnn_pkg::MODE_LOAD) || out_free);
  assign acc      = in_valid && in_ready;
  assign ram_we   = acc && (in_mode == mnn_pkg::MODE_LOAD) &&
                    (cnt_r < mnn_pkg::CNT_BITS'(mnn_pkg::MAX_POINTS));

  // result register gets a new word this cycle
  assign out_load = ((state_r == ST_IDLE) && acc && (in_mode == mnn_pkg::MODE_QUERY) &&
                     (({1'b0, in_point_index} >= cnt_r) ||
                      (cnt_r == mnn_pkg::CNT_BITS'(1)))) ||
                    ((state_r == ST_DONE) && out_free);

  // read address: queried point first, then the scan
  always_comb begin
    unique case (state_r)
      ST_IDLE:  raddr = in_point_index;
      ST_LATCH: raddr = '0;
      default:  raddr = j_r + 1'b1;
    endcase
  end

  mnn_ram #(.WIDTH(mnn_pkg::PT_BITS), .DEPTH(mnn_pkg::MAX_POINTS)) u_pt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[mnn_pkg::IDX_BITS-1:0]),
    .wdata ({in_x_coord, in_y_coord}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // distance of the scanned point and running minimum
  assign rx   = rdata[mnn_pkg::PT_BITS-1:mnn_pkg::COORD_BITS];
  assign ry   = rdata[mnn_pkg::COORD_BITS-1:0];
  assign dx   = mnn_pkg::DIST_BITS'(rx) - mnn_pkg::DIST_BITS'(px_r);
  assign dy   = mnn_pkg::DIST_BITS'(ry) - mnn_pkg::DIST_BITS'(py_r);
  assign ax   = dx[mnn_pkg::DIST_BITS-1] ? mnn_pkg::DIST_BITS'(-dx) : mnn_pkg::DIST_BITS'(dx);
  assign ay   = dy[mnn_pkg::DIST_BITS-1] ? mnn_pkg::DIST_BITS'(-dy) : mnn_pkg::DIST_BITS'(dy);
  assign pt_dist = ax + ay;
  assign best_nxt = ((j_r != qidx_r) && (pt_dist < best_r)) ? pt_dist : best_r;
  assign last = ({1'b0, j_r} == (cnt_r - 1'b1));

  // control and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (acc) begin
            if (in_mode == mnn_pkg::MODE_LOAD) begin
              if (ram_we) begin
                cnt_r <= cnt_r + 1'b1;
              end
            end else if ({1'b0, in_point_index} >= cnt_r) begin
              out_dist_r  <= '0;
              out_alone_r <= 1'b0;
              out_bad_r   <= 1'b1;
            end else if (cnt_r == mnn_pkg::CNT_BITS'(1)) begin
              out_dist_r  <= '0;
              out_alone_r <= 1'b1;
              out_bad_r   <= 1'b0;
            end else begin
              qidx_r  <= in_point_index;
              state_r <= ST_LATCH;
            end
          end
        end
        ST_LATCH: begin
          px_r    <= rx;
          py_r    <= ry;
          j_r     <= '0;
          best_r  <= '1;
          state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          best_r <= best_nxt;
          if (last) begin
            state_r <= ST_DONE;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_dist_r  <= best_r;
            out_alone_r <= 1'b0;
            out_bad_r   <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_distance  = out_dist_r;
  assign out_alone     = out_alone_r;
  assign out_bad_index = out_bad_r;

  // checks
  `MNN_ASSERT_ALWAYS(a_cnt_max, clk, rst_n, cnt_r <= mnn_pkg::CNT_BITS'(mnn_pkg::MAX_POINTS), "point count over max")
  `MNN_ASSERT(a_scan_two, clk, rst_n, (state_r == ST_SCAN) |-> (cnt_r >= mnn_pkg::CNT_BITS'(2)), "scan with fewer than two points")
  `MNN_ASSERT(a_flags_excl, clk, rst_n, out_valid_r |-> !(out_alone_r && out_bad_r), "alone and bad index together")
endmodule
